// ===== hw/rtl/ipv4hc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4hc_pkg: shared constants for the IPv4 receive header checker
// Status codes, header word positions and field widths.
// ----------------------------------------------------------------------------
package ipv4hc_pkg;

    localparam int WORD_W   = 16;
    localparam int IDX_W    = 5;
    localparam int IHL_W    = 4;
    localparam int HBYTES_W = 6;
    localparam int STATUS_W = 3;

    // result status codes, in priority order of the faults
    localparam logic [STATUS_W-1:0] STATUS_ACCEPTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_IHL_SHORT = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CSUM  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_LEN_SHORT = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NOT_LOCAL = 3'd4;

    // header word positions
    localparam logic [IDX_W-1:0] WIDX_TOTAL_LEN = 5'd1;
    localparam logic [IDX_W-1:0] WIDX_PROTO     = 5'd4;
    localparam logic [IDX_W-1:0] WIDX_CHECKSUM  = 5'd5;
    localparam logic [IDX_W-1:0] WIDX_SRC_HI    = 5'd6;
    localparam logic [IDX_W-1:0] WIDX_SRC_LO    = 5'd7;
    localparam logic [IDX_W-1:0] WIDX_DST_HI    = 5'd8;
    localparam logic [IDX_W-1:0] WIDX_DST_LO    = 5'd9;

    localparam logic [IHL_W-1:0] IHL_MIN        = 4'd5;
    localparam logic [7:0]       PROTO_ICMP     = 8'd1;
    localparam logic [31:0]      BROADCAST_ADDR = 32'hFFFF_FFFF;

endpackage

// ===== hw/rtl/ipv4_rx_header_checker_unit.sv =====
// ----------------------------------------------------------------------------
// ipv4_rx_header_checker_unit: IPv4 receive header checker
// Output: a result beat is registered and valid in the cycle after the last header beat is taken.
// Throughput: one header word per cycle; a header is IHL*2 words (only its first
// word when IHL is below five), and a waiting result only holds the input while
// m_tready is low.
// Reset: aresetn (sync, active low) clears the word tracking, the output valid
// and local_address; header field and result registers are left as they are.
// ----------------------------------------------------------------------------
module ipv4_rx_header_checker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: local IPv4 address
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    // header word beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] header_word
    input  logic [0:0]  s_tuser,   // [0] first_word
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [7:0] protocol, [39:8] source_address,
                                   // [45:40] header_bytes, [61:46] payload_length,
                                   // [63:62] zero
    output logic [3:0]  m_tuser    // [2:0] status, [3] deliver_icmp
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [31:0]                      local_addr_reg;

    logic                             in_header_reg, in_header_next;
    logic [ipv4hc_pkg::IDX_W-1:0]     word_idx_reg, word_idx_next;
    logic [ipv4hc_pkg::IHL_W-1:0]     ihl_reg, ihl_next;
    // ones' complement sum, checksum word left out, carries folded back on every added word
    logic [15:0]                      sum_reg, sum_next;
    logic [15:0]                      csum_reg, csum_next;
    logic [15:0]                      tlen_reg, tlen_next;
    logic [7:0]                       proto_reg, proto_next;
    logic [31:0]                      src_reg, src_next;
    logic [31:0]                      dst_reg, dst_next;

    logic                             m_valid_reg;
    logic [ipv4hc_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [7:0]                       res_proto_reg, res_proto_next;
    logic [31:0]                      res_src_reg, res_src_next;
    logic [ipv4hc_pkg::HBYTES_W-1:0]  hbytes_reg, hbytes_next;
    logic [15:0]                      payload_reg, payload_next;
    logic                             icmp_reg, icmp_next;

    // ------------------------------------------------------------------
    // Beat decode
    // ------------------------------------------------------------------
    logic                             beat;
    logic                             first;
    logic                             active;
    logic                             ihl_short;
    logic                             last_word;
    logic                             emit;
    logic [ipv4hc_pkg::IDX_W-1:0]     idx;
    logic [ipv4hc_pkg::IHL_W-1:0]     ihl_cur;
    logic [15:0]                      sum_base;
    logic [16:0]                      sum_add;
    logic [15:0]                      sum_fold;
    logic [ipv4hc_pkg::HBYTES_W-1:0]  hbytes;
    logic                             short_len;
    logic                             csum_bad;
    logic                             addr_miss;

    // output stage takes a new result whenever it is empty or draining
    assign s_tready = !m_valid_reg || m_tready;
    assign beat     = s_tvalid && s_tready;
    assign first    = s_tuser[0];
    assign active   = first || in_header_reg;

    assign idx       = first ? '0 : word_idx_reg;
    assign ihl_cur   = first ? s_tdata[11:8] : ihl_reg;
    assign ihl_short = first && (s_tdata[11:8] < ipv4hc_pkg::IHL_MIN);
    // last header word is IHL*2-1
    assign last_word = ({1'b0, idx} + 6'd1) >= {1'b0, ihl_cur, 1'b0};
    assign hbytes    = {ihl_cur, 2'b00};

    // end-around carry add of this word
    assign sum_base = first ? '0 : sum_reg;
    assign sum_add  = {1'b0, sum_base} + {1'b0, s_tdata};
    assign sum_fold = sum_add[15:0] + {15'd0, sum_add[16]};

    always_comb begin
        ihl_next  = ihl_cur;
        sum_next  = (idx == ipv4hc_pkg::WIDX_CHECKSUM) ? sum_base : sum_fold;
        csum_next = csum_reg;
        tlen_next = tlen_reg;
        proto_next = proto_reg;
        src_next  = src_reg;
        dst_next  = dst_reg;
        case (idx)
            ipv4hc_pkg::WIDX_TOTAL_LEN: tlen_next       = s_tdata;
            ipv4hc_pkg::WIDX_PROTO:     proto_next      = s_tdata[7:0];
            ipv4hc_pkg::WIDX_CHECKSUM:  csum_next       = s_tdata;
            ipv4hc_pkg::WIDX_SRC_HI:    src_next[31:16] = s_tdata;
            ipv4hc_pkg::WIDX_SRC_LO:    src_next[15:0]  = s_tdata;
            ipv4hc_pkg::WIDX_DST_HI:    dst_next[31:16] = s_tdata;
            ipv4hc_pkg::WIDX_DST_LO:    dst_next[15:0]  = s_tdata;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Classification on the last word
    // ------------------------------------------------------------------
    assign short_len = tlen_next < {10'd0, hbytes};
    assign csum_bad  = (~sum_next) != csum_next;
    assign addr_miss = (dst_next != local_addr_reg) &&
                       (dst_next != ipv4hc_pkg::BROADCAST_ADDR);
    assign emit      = beat && active && (ihl_short || last_word);

    always_comb begin
        status_next    = ipv4hc_pkg::STATUS_ACCEPTED;
        res_proto_next = proto_next;
        res_src_next   = src_next;
        hbytes_next    = hbytes;
        payload_next   = short_len ? 16'd0 : (tlen_next - {10'd0, hbytes});
        if (ihl_short) begin
            status_next    = ipv4hc_pkg::STATUS_IHL_SHORT;
            res_proto_next = '0;
            res_src_next   = '0;
            payload_next   = '0;
        end else if (csum_bad) begin
            status_next = ipv4hc_pkg::STATUS_BAD_CSUM;
        end else if (short_len) begin
            status_next = ipv4hc_pkg::STATUS_LEN_SHORT;
        end else if (addr_miss) begin
            status_next = ipv4hc_pkg::STATUS_NOT_LOCAL;
        end
        icmp_next = (status_next == ipv4hc_pkg::STATUS_ACCEPTED) &&
                    (res_proto_next == ipv4hc_pkg::PROTO_ICMP);
    end

    // word tracking
    always_comb begin
        in_header_next = in_header_reg;
        word_idx_next  = word_idx_reg;
        if (beat && active) begin
            if (ihl_short || last_word) begin
                in_header_next = 1'b0;
                word_idx_next  = '0;
            end else begin
                in_header_next = 1'b1;
                word_idx_next  = idx + 5'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_addr_reg <= '0;
            in_header_reg  <= 1'b0;
            word_idx_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                local_addr_reg <= cfg_wr_data;
            end
            in_header_reg <= in_header_next;
            word_idx_reg  <= word_idx_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Header fields and result payload
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (beat && active) begin
            ihl_reg   <= ihl_next;
            sum_reg   <= sum_next;
            csum_reg  <= csum_next;
            tlen_reg  <= tlen_next;
            proto_reg <= proto_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
        end
        if (emit) begin
            status_reg    <= status_next;
            res_proto_reg <= res_proto_next;
            res_src_reg   <= res_src_next;
            hbytes_reg    <= hbytes_next;
            payload_reg   <= payload_next;
            icmp_reg      <= icmp_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, payload_reg, hbytes_reg, res_src_reg, res_proto_reg};
    assign m_tuser  = {icmp_reg, status_reg};

endmodule

// ===== hw/rtl/ipv4hc_checker.sv =====
// ----------------------------------------------------------------------------
// ipv4hc_checker: port-level checks for the IPv4 receive header checker
// Bound to the top level; looks at the stream ports only.
// ----------------------------------------------------------------------------
module ipv4hc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [3:0]  m_tuser
);

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // no result appears without an input beat
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !(s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result without input beat");

    a_icmp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |->
            m_tuser[2:0] == ipv4hc_pkg::STATUS_ACCEPTED &&
            m_tdata[7:0] == ipv4hc_pkg::PROTO_ICMP)
        else $error("deliver_icmp on rejected or non-ICMP packet");

    a_ihl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] == ipv4hc_pkg::STATUS_IHL_SHORT |->
            m_tdata[39:0] == 40'd0 && m_tdata[61:46] == 16'd0 &&
            m_tdata[45:40] < 6'd20)
        else $error("short IHL result fields wrong");

    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] != ipv4hc_pkg::STATUS_IHL_SHORT |->
            m_tdata[45:40] >= 6'd20 && m_tuser[2:0] <= ipv4hc_pkg::STATUS_NOT_LOCAL)
        else $error("complete header result out of range");

endmodule

bind ipv4_rx_header_checker_unit ipv4hc_checker u_ipv4hc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
